// ===== hdl/hhe_pkg.sv =====
package hhe_pkg;

  // Widths of the fixed fields
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned HOST_LEN_W = 8;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  localparam logic [POS_W-1:0]  PREFIX_LEN         = 3'd6;
  localparam logic [POS_W-1:0]  POS_SAT            = 3'd7;
  localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = 16'd80;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SEEK     = 2'd0,
    PH_HOST     = 2'd1,
    PH_PORT     = 2'd2,
    PH_PORT_END = 2'd3
  } phase_t;

  // One queued word: an optional main result, optionally followed by not found
  typedef struct packed {
    logic              has_main;
    kind_t             kind;
    logic [BYTE_W-1:0] host_char;
    logic [PORT_W-1:0] port;
    logic              last;
    logic              has_nf;
  } action_t;

  // Expected byte of the "Host: " prefix at a line position
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    unique case (pos)
      3'd0:    c = CH_H;
      3'd1:    c = CH_O;
      3'd2:    c = CH_S;
      3'd3:    c = CH_T;
      3'd4:    c = CH_COLON;
      3'd5:    c = CH_SPACE;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hhe_in_if.sv =====
interface hhe_in_if import hhe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/hhe_out_if.sv =====
interface hhe_out_if import hhe_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [BYTE_W-1:0] host_char;
  logic [PORT_W-1:0] port;
  logic              last;

  modport source (output valid, output kind, output host_char, output port, output last,
                  input ready);
  modport sink   (input valid, input kind, input host_char, input port, input last,
                  output ready);
endinterface

// ===== hdl/hhe_cfg_if.sv =====
interface hhe_cfg_if import hhe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] default_port;

  modport source (output valid, output default_port, input ready);
  modport sink   (input valid, input default_port, output ready);
endinterface

// ===== hdl/hhe_front.sv =====
module hhe_front import hhe_pkg::*; #(
  parameter int unsigned HOST_MAX = 127
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  logic              cfg_valid,
  input  logic [PORT_W-1:0] cfg_port,
  input  logic              q_full,
  output logic              q_push,
  output action_t           q_data
);

  logic [PORT_W-1:0]     default_port_r;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  pm_r, pm_nxt;
  phase_t                phase_r, phase_nxt;
  logic [PORT_W-1:0]     acc_r, acc_nxt;
  logic [HOST_LEN_W-1:0] len_r, len_nxt;
  logic                  colon_r, colon_nxt;
  logic                  fin_r, fin_nxt;
  logic                  in_acc;
  logic                  in_host;
  action_t               act;

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  // Parse one byte
  always_comb begin
    pos_nxt   = pos_r;
    pm_nxt    = pm_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    colon_nxt = colon_r;
    fin_nxt   = fin_r;
    in_host   = 1'b0;
    act       = '0;
    act.kind  = KIND_CHAR;

    if (!fin_r) begin
      in_host = (phase_r != PH_SEEK);
      if (!in_host) begin
        if (data_byte == CH_LF) begin
          pos_nxt   = '0;
          pm_nxt    = 1'b1;
          phase_nxt = PH_SEEK;
          acc_nxt   = '0;
          len_nxt   = '0;
          colon_nxt = 1'b0;
        end else if (pos_r == PREFIX_LEN && pm_r && data_byte != CH_CR) begin
          phase_nxt = PH_HOST;
          pos_nxt   = POS_SAT;
          in_host   = 1'b1;
        end else begin
          if (data_byte == CH_CR) begin
            pm_nxt = 1'b0;
          end else if (pos_r < PREFIX_LEN && data_byte != prefix_char(pos_r)) begin
            pm_nxt = 1'b0;
          end
          if (pos_r < POS_SAT) begin
            pos_nxt = pos_r + 3'd1;
          end
        end
      end

      if (in_host) begin
        if (data_byte == CH_LF) begin
          pos_nxt   = '0;
          pm_nxt    = 1'b1;
          phase_nxt = PH_SEEK;
          acc_nxt   = '0;
          len_nxt   = '0;
          colon_nxt = 1'b0;
        end else if (data_byte == CH_CR) begin
          act.has_main = 1'b1;
          act.kind     = KIND_FOUND;
          act.port     = colon_r ? acc_r : default_port_r;
          act.last     = 1'b1;
          fin_nxt      = 1'b1;
        end else if (phase_nxt == PH_HOST) begin
          if (data_byte == CH_COLON) begin
            colon_nxt = 1'b1;
            phase_nxt = PH_PORT;
          end else if (len_r >= HOST_LEN_W'(HOST_MAX)) begin
            act.has_main = 1'b1;
            act.kind     = KIND_OVERFLOW;
            act.last     = 1'b1;
            fin_nxt      = 1'b1;
          end else begin
            len_nxt       = len_r + 8'd1;
            act.has_main  = 1'b1;
            act.kind      = KIND_CHAR;
            act.host_char = data_byte;
          end
        end else if (phase_nxt == PH_PORT) begin
          if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
            // acc * 10 + digit, wrapped to 16 bits
            acc_nxt = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0}
                    + {8'h00, data_byte - CH_ZERO};
          end else begin
            phase_nxt = PH_PORT_END;
          end
        end
      end
    end

    // Close the request
    if (last_byte) begin
      act.has_nf = !fin_nxt;
      pos_nxt    = '0;
      pm_nxt     = 1'b1;
      phase_nxt  = PH_SEEK;
      acc_nxt    = '0;
      len_nxt    = '0;
      colon_nxt  = 1'b0;
      fin_nxt    = 1'b0;
    end
  end

  assign q_push = in_acc && (act.has_main || act.has_nf);
  assign q_data = act;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_port_r <= DEFAULT_PORT_RESET;
      pos_r          <= '0;
      pm_r           <= 1'b1;
      phase_r        <= PH_SEEK;
      acc_r          <= '0;
      len_r          <= '0;
      colon_r        <= 1'b0;
      fin_r          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_port_r <= cfg_port;
      end
      if (in_acc) begin
        pos_r   <= pos_nxt;
        pm_r    <= pm_nxt;
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        len_r   <= len_nxt;
        colon_r <= colon_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && in_acc && !last_byte) |-> !q_push)
    else $error("word queued after final result");
  a_seek_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEEK) |-> (len_r == '0 && !colon_r && acc_r == '0))
    else $error("host state left over while seeking");
`endif

endmodule

// ===== hdl/hhe_fifo.sv =====
module hhe_fifo import hhe_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  action_t push_data,
  input  logic    pop,
  output action_t pop_data,
  output logic    full,
  output logic    empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  action_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/hhe_back.sv =====
module hhe_back import hhe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  action_t           q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [BYTE_W-1:0] out_host_char,
  output logic [PORT_W-1:0] out_port,
  output logic              out_last
);

  logic              vld_r;
  logic              pend_r;
  kind_t             kind_r;
  logic [BYTE_W-1:0] char_r;
  logic [PORT_W-1:0] port_r;
  logic              last_r;
  logic              load;

  assign load  = !vld_r || out_ready;
  assign q_pop = load && !pend_r && !q_empty;

  // Control: valid and pending not-found
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        vld_r  <= 1'b1;
        pend_r <= 1'b0;
      end else if (!q_empty) begin
        vld_r  <= 1'b1;
        pend_r <= q_data.has_main && q_data.has_nf;
      end else begin
        vld_r <= 1'b0;
      end
    end
  end

  // Payload: main result first, not found after it
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r || (!q_empty && !q_data.has_main)) begin
        kind_r <= KIND_NOT_FOUND;
        char_r <= '0;
        port_r <= '0;
        last_r <= 1'b1;
      end else if (!q_empty) begin
        kind_r <= q_data.kind;
        char_r <= q_data.host_char;
        port_r <= q_data.port;
        last_r <= q_data.last;
      end
    end
  end

  assign out_valid     = vld_r;
  assign out_kind      = kind_r;
  assign out_host_char = char_r;
  assign out_port      = port_r;
  assign out_last      = last_r;

`ifndef NO_ASSERTIONS
  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> vld_r)
    else $error("pending not-found without a result shown");
  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> !q_pop)
    else $error("queue popped while a not-found is pending");
`endif

endmodule

// ===== hdl/http_host_header_extractor.sv =====
// A byte's result is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that yields a
// host character and a not-found result shows both words on the output register in turn.
// A FIFO_DEPTH-word queue between the parser and the output stage absorbs stalls.
// Reset (rst_n, synchronous, active low) clears the parser, the queue and the
// output; default_port returns to 80.
module http_host_header_extractor import hhe_pkg::*; #(
  parameter int unsigned HOST_MAX   = 127,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  hhe_in_if.sink    in_if,
  hhe_out_if.source out_if,
  hhe_cfg_if.sink   cfg_if
);

  logic    q_full, q_empty, q_push, q_pop;
  action_t q_wdata, q_rdata;
  kind_t   out_kind;

  assign cfg_if.ready = 1'b1;

  hhe_front #(.HOST_MAX(HOST_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .data_byte (in_if.data_byte),
    .last_byte (in_if.last_byte),
    .cfg_valid (cfg_if.valid),
    .cfg_port  (cfg_if.default_port),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  hhe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  hhe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_kind      (out_kind),
    .out_host_char (out_if.host_char),
    .out_port      (out_if.port),
    .out_last      (out_if.last)
  );

  assign out_if.kind = out_kind;

endmodule

// ===== verif/hhe_checker.sv =====
`timescale 1ns / 100ps

module hhe_checker import hhe_pkg::*; #(
  parameter int unsigned HOST_MAX = 127
) (
  input  logic clk,
  input  logic rst_n,
  hhe_in_if    in_w,
  hhe_out_if   out_w,
  hhe_cfg_if   cfg_w,
  output int   fail_count,
  output int   words_pending,
  output int   chars_seen,
  output int   found_seen,
  output int   missing_seen,
  output int   overflow_seen
);

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] host_char;
    logic [PORT_W-1:0] port;
    logic              last;
  } host_word_t;

  // "Host: " laid out so that index 0 is the first byte of a line
  localparam logic [5:0][BYTE_W-1:0] HOST_TAG =
    {CH_SPACE, CH_COLON, CH_T, CH_S, CH_O, CH_H};

  host_word_t        predicted_words[$];
  logic [PORT_W-1:0] dflt_port;
  logic [POS_W-1:0]  line_pos;
  logic              tag_ok;
  phase_t            scan_phase;
  logic [PORT_W-1:0] port_acc;
  logic [7:0]        host_len;
  logic              colon_seen;
  logic              req_done;

  // Start a fresh line
  task automatic clear_line_state();
    line_pos   = '0;
    tag_ok     = 1'b1;
    scan_phase = PH_SEEK;
    port_acc   = '0;
    host_len   = '0;
    colon_seen = 1'b0;
  endtask

  task automatic push_word(input kind_t k, input logic [BYTE_W-1:0] c,
                           input logic [PORT_W-1:0] p, input logic l);
    predicted_words.push_back('{kind: k, host_char: c, port: p, last: l});
  endtask

  task automatic note_fail(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Advance the host line scanner by one request byte
  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic on_host_line;
    on_host_line = (scan_phase != PH_SEEK);
    if (!req_done) begin
      if (!on_host_line) begin
        if (b == CH_LF) begin
          clear_line_state();
        end else if (line_pos == PREFIX_LEN && tag_ok && b != CH_CR) begin
          scan_phase   = PH_HOST;
          line_pos     = POS_SAT;
          on_host_line = 1'b1;
        end else begin
          if (b == CH_CR) begin
            tag_ok = 1'b0;
          end else if (line_pos < PREFIX_LEN && b != HOST_TAG[line_pos]) begin
            tag_ok = 1'b0;
          end
          if (line_pos < POS_SAT) begin
            line_pos++;
          end
        end
      end
      if (on_host_line) begin
        if (b == CH_LF) begin
          clear_line_state();
        end else if (b == CH_CR) begin
          push_word(KIND_FOUND, '0, colon_seen ? port_acc : dflt_port, 1'b1);
          req_done = 1'b1;
        end else if (scan_phase == PH_HOST) begin
          if (b == CH_COLON) begin
            colon_seen = 1'b1;
            scan_phase = PH_PORT;
          end else if (host_len >= HOST_MAX) begin
            push_word(KIND_OVERFLOW, '0, '0, 1'b1);
            req_done = 1'b1;
          end else begin
            host_len++;
            push_word(KIND_CHAR, b, '0, 1'b0);
          end
        end else if (scan_phase == PH_PORT) begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            port_acc = PORT_W'(port_acc * 10 + (b - CH_ZERO));
          end else begin
            scan_phase = PH_PORT_END;
          end
        end
      end
    end
    if (fin) begin
      if (!req_done) begin
        push_word(KIND_NOT_FOUND, '0, '0, 1'b1);
      end
      clear_line_state();
      req_done = 1'b0;
    end
  endtask

  // Compare one accepted result word with the oldest prediction
  task automatic check_word();
    host_word_t want;
    unique case (out_w.kind)
      KIND_CHAR:      chars_seen++;
      KIND_FOUND:     found_seen++;
      KIND_NOT_FOUND: missing_seen++;
      default:        overflow_seen++;
    endcase
    if (predicted_words.size() == 0) begin
      note_fail($sformatf("unexpected word: kind %0d char %02h port %0d last %0b",
                          out_w.kind, out_w.host_char, out_w.port, out_w.last));
    end else begin
      want = predicted_words.pop_front();
      if (out_w.kind !== want.kind || out_w.host_char !== want.host_char ||
          out_w.port !== want.port || out_w.last !== want.last) begin
        note_fail($sformatf({"mismatch: expected kind %0d char %02h port %0d last %0b,",
                             " got kind %0d char %02h port %0d last %0b"},
                            want.kind, want.host_char, want.port, want.last,
                            out_w.kind, out_w.host_char, out_w.port, out_w.last));
      end
    end
  endtask

  // Track config, predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_words.delete();
      dflt_port     = DEFAULT_PORT_RESET;
      req_done      = 1'b0;
      fail_count    = 0;
      chars_seen    = 0;
      found_seen    = 0;
      missing_seen  = 0;
      overflow_seen = 0;
      clear_line_state();
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        dflt_port = cfg_w.default_port;
      end
      if (in_w.valid && in_w.ready) begin
        parse_byte(in_w.data_byte, in_w.last_byte);
      end
      if (out_w.valid && out_w.ready) begin
        check_word();
      end
    end
    words_pending = predicted_words.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import hhe_pkg::*; ();

  localparam int unsigned HOST_MAX        = 127;
  localparam int          SEG_ITEMS       = 290;
  localparam int          QUIET_CYCLES    = 16;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          WATCHDOG_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n;

  hhe_in_if  in_w();
  hhe_out_if out_w();
  hhe_cfg_if cfg_w();

  int chk_fails, chk_pending;
  int chars_seen, found_seen, missing_seen, overflow_seen;

  logic [BYTE_W-1:0] req_q[$];
  int   req_counted;
  int   bytes_sent    = 0;
  int   requests_sent = 0;
  int   snd_idle_pct  = 11;
  int   rcv_idle_pct  = 60;
  int   stall_cycles  = 0;
  logic holding       = 1'b0;
  event hold_ev;

  http_host_header_extractor #(.HOST_MAX(HOST_MAX)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_w),
    .out_if (out_w),
    .cfg_if (cfg_w)
  );

  hhe_checker #(.HOST_MAX(HOST_MAX)) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_w          (in_w),
    .out_w         (out_w),
    .cfg_w         (cfg_w),
    .fail_count    (chk_fails),
    .words_pending (chk_pending),
    .chars_seen    (chars_seen),
    .found_seen    (found_seen),
    .missing_seen  (missing_seen),
    .overflow_seen (overflow_seen)
  );

  always #5 clk = ~clk;

  // Receiver: random back-pressure, or a long hold-off when asked
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_w.ready <= !holding && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Hold the receiver off for a fixed stretch of cycles
  initial begin
    forever begin
      @(hold_ev);
      holding = 1'b1;
      repeat (HOLD_CYCLES) begin
        @(posedge clk);
        stall_cycles++;
      end
      holding = 1'b0;
    end
  end

  // Watchdog: end the run if no channel moves a word for too long
  int idle_run = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) ||
          (cfg_w.valid && cfg_w.ready)) begin
        idle_run <= 0;
      end else if (idle_run == WATCHDOG_CYCLES) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  function automatic logic [BYTE_W-1:0] host_byte();
    string pool = "abcdefghijklmnopqrstuvwxyz0123456789.-";
    logic [BYTE_W-1:0] b;
    if ($urandom_range(99) < 85) begin
      return pool[$urandom_range(pool.len() - 1)];
    end
    b = BYTE_W'($urandom_range(255));
    while (b == CH_CR || b == CH_LF || b == CH_COLON) begin
      b = BYTE_W'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      req_q.push_back(s[i]);
    end
  endtask

  task automatic add_crlf();
    req_q.push_back(CH_CR);
    req_q.push_back(CH_LF);
  endtask

  task automatic add_host(input int n);
    repeat (n) req_q.push_back(host_byte());
  endtask

  // Colon, up to seven digits (enough to wrap 16 bits), maybe trailing junk
  task automatic add_port();
    req_q.push_back(CH_COLON);
    repeat ($urandom_range(7)) req_q.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) req_q.push_back(host_byte());
    end
  endtask

  task automatic add_junk_line();
    if ($urandom_range(4) == 0) begin
      req_q.push_back(CH_LF);
    end else begin
      add_host($urandom_range(10));
      add_crlf();
    end
  endtask

  task automatic add_short_host_line();
    add_text("Host: ");
    add_host($urandom_range(6, 1));
    add_crlf();
  endtask

  // Build one request: mostly well-formed, the rest near misses and noise
  task automatic build_request();
    int pick, cut, base, pos;
    req_q.delete();
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(3) == 0) begin
        add_text("GET / HTTP/1.1");
        add_crlf();
      end
      repeat ($urandom_range(2)) add_junk_line();
      add_text("Host: ");
      add_host(($urandom_range(99) < 3) ? $urandom_range(135, 125) : $urandom_range(12));
      if ($urandom_range(99) < 70) begin
        add_port();
      end
      add_crlf();
      if ($urandom_range(99) < 15) begin
        // end the request early, often inside the host line
        cut = $urandom_range(req_q.size(), 1);
        while (req_q.size() > cut) req_q.pop_back();
        req_counted = req_q.size();
      end else begin
        repeat ($urandom_range(2)) add_junk_line();
        req_counted = req_q.size();
      end
    end else if (pick < 65) begin
      // host line broken by a bare LF, sometimes followed by a good one
      add_text("Host: ");
      add_host($urandom_range(6, 1));
      if ($urandom_range(1)) begin
        add_port();
      end
      req_q.push_back(CH_LF);
      if ($urandom_range(1)) begin
        add_short_host_line();
      end
      req_counted = req_q.size();
    end else if (pick < 80) begin
      // damaged prefix: early CR, case flip or random byte
      base = req_q.size();
      add_text("Host: ");
      pos = $urandom_range(5);
      case ($urandom_range(2))
        0:       req_q[base + pos] = CH_CR;
        1:       req_q[base + pos] = req_q[base + pos] ^ 8'h20;
        default: req_q[base + pos] = BYTE_W'($urandom_range(255));
      endcase
      add_host($urandom_range(8, 1));
      if ($urandom_range(1)) begin
        add_port();
      end
      add_crlf();
      if ($urandom_range(99) < 40) begin
        add_short_host_line();
      end
      req_counted = req_q.size();
    end else if (pick < 88) begin
      // prefix with nothing after it
      add_text($urandom_range(1) ? "Host: " : "Host:");
      add_crlf();
      if ($urandom_range(1)) begin
        add_short_host_line();
      end
      req_counted = req_q.size();
    end else begin
      repeat ($urandom_range(20, 1)) req_q.push_back(BYTE_W'($urandom_range(255)));
      req_counted = req_q.size();
    end
  endtask

  // Offer one byte, with random idle cycles first, and wait for acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_w.valid <= 1'b0;
      @(negedge clk);
    end
    in_w.valid     <= 1'b1;
    in_w.data_byte <= b;
    in_w.last_byte <= fin;
    do @(posedge clk); while (!in_w.ready);
  endtask

  task automatic send_request();
    for (int i = 0; i < req_q.size(); i++) begin
      send_byte(req_q[i], i == req_q.size() - 1);
    end
    bytes_sent += req_q.size();
    requests_sent++;
  endtask

  // Drop valid and let every expected word drain out
  task automatic wait_quiet();
    @(negedge clk);
    in_w.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_port(input logic [PORT_W-1:0] v);
    @(negedge clk);
    cfg_w.valid        <= 1'b1;
    cfg_w.default_port <= v;
    do @(posedge clk); while (!cfg_w.ready);
    @(negedge clk);
    cfg_w.valid <= 1'b0;
  endtask

  initial begin
    int seg_bytes;
    logic [PORT_W-1:0] seg_port;
    rst_n              = 1'b0;
    in_w.valid         = 1'b0;
    in_w.data_byte     = '0;
    in_w.last_byte     = 1'b0;
    cfg_w.valid        = 1'b0;
    cfg_w.default_port = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: port that wraps past 16 bits at reset default
    req_q.delete();
    add_text("Host: a:70000");
    req_q.push_back(CH_CR);
    send_request();
    // NUL and 0xFF host bytes, request ends on a host byte
    req_q.delete();
    add_text("Host: ");
    req_q.push_back(8'h00);
    req_q.push_back(8'hFF);
    send_request();
    // lone LF as a whole request
    req_q.delete();
    req_q.push_back(CH_LF);
    send_request();

    // Random segments, each writing a default port; each pair of segments shares an idle profile
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0:       begin snd_idle_pct = 11; rcv_idle_pct = 60; end
        1:       begin snd_idle_pct = 60; rcv_idle_pct = 11; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      case (seg)
        0:       seg_port = '0;
        1:       seg_port = '1;
        5:       seg_port = DEFAULT_PORT_RESET;
        default: seg_port = PORT_W'($urandom_range(65535));
      endcase
      wait_quiet();
      write_port(seg_port);
      if (seg == 4) begin
        -> hold_ev;
      end
      seg_bytes = 0;
      while (seg_bytes < SEG_ITEMS) begin
        build_request();
        send_request();
        seg_bytes += req_counted;
      end
    end
    wait_quiet();

    $display("Sent %0d bytes in %0d requests; default port set to 0, 65535, 80 and random.",
             bytes_sent, requests_sent);
    $display("Checked %0d host bytes, %0d found, %0d not found, %0d overflow; %0d hold cycles.",
             chars_seen, found_seen, missing_seen, overflow_seen, stall_cycles);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures, %0d words still expected", chk_fails, chk_pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hhe_pkg.sv
hdl/hhe_in_if.sv
hdl/hhe_out_if.sv
hdl/hhe_cfg_if.sv
hdl/hhe_front.sv
hdl/hhe_fifo.sv
hdl/hhe_back.sv
hdl/http_host_header_extractor.sv
verif/hhe_checker.sv
verif/tb_top.sv
